FILE: hw/rtl/mrtu_pkg.sv
// Shared types, constants and CRC-16 functions for the Modbus RTU frame receiver.
// No dependencies; imported by the front end, queue, back end, top level and testbench.
`default_nettype none
package mrtu_pkg;

    localparam int MAX_FRAME_DEFAULT = 256;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  FC_READ_INPUT   = 8'h04;
    localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0]  FC_WRITE_MULTI  = 8'h10;
    localparam logic [8:0]  SHORT_DATA_LEN  = 9'd6;
    localparam logic [8:0]  MULTI_HEAD_LEN  = 9'd5;
    localparam logic [8:0]  MULTI_SPAN_BASE = 9'd7;
    localparam logic [8:0]  MULTI_TAIL_LEN  = 9'd2;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CODE,
        PH_DATA,
        PH_HEAD
    } rx_phase_t;

    typedef enum logic [2:0] {
        CRC_NONE,
        CRC_START,
        CRC_FEED,
        CRC_CHK_LO,
        CRC_CHK_HI
    } crc_op_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [8:0] byte_index;
        logic       frame_end;
        logic       aborted;
        logic       len_ok;
        crc_op_t    op;
    } mrtu_entry_t;

    function automatic logic [15:0] crc16_entry(input logic [7:0] idx);
        logic [15:0] c;
        c = {8'h00, idx};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        return {8'h00, crc[15:8]} ^ crc16_entry(crc[7:0] ^ b);
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mrtu_front.sv
// Front end: tracks the frame phase and counters, tags each frame word with its CRC action.
// Depends on mrtu_pkg.
`default_nettype none
module mrtu_front
    import mrtu_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  slave_address,
    input  wire logic        in_valid,
    input  wire logic [7:0]  in_byte,
    output logic             push,
    output mrtu_entry_t      push_entry
);

    localparam logic [9:0] MaxLen = 10'(MAX_FRAME);

    rx_phase_t  phase_reg, phase_next;
    logic [8:0] remaining_reg, remaining_next;
    logic [8:0] span_reg, span_next;
    logic [8:0] count_reg, count_next;

    logic is_short_code;
    logic last_in_phase;

    assign is_short_code = (in_byte == FC_READ_HOLDING) || (in_byte == FC_READ_INPUT) ||
                           (in_byte == FC_WRITE_SINGLE);
    assign last_in_phase = (remaining_reg <= 9'd1);

    always_comb begin
        phase_next = phase_reg;
        if (in_valid) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (in_byte == slave_address) phase_next = PH_CODE;
                end
                PH_CODE: begin
                    if (is_short_code) phase_next = PH_DATA;
                    else if (in_byte == FC_WRITE_MULTI) phase_next = PH_HEAD;
                    else phase_next = PH_IDLE;
                end
                PH_HEAD: begin
                    if (last_in_phase) phase_next = PH_DATA;
                end
                PH_DATA: begin
                    if (last_in_phase) phase_next = PH_IDLE;
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        push                  = 1'b0;
        push_entry.frame_byte = in_byte;
        push_entry.byte_index = count_reg;
        push_entry.frame_end  = 1'b0;
        push_entry.aborted    = 1'b0;
        push_entry.len_ok     = 1'b0;
        push_entry.op         = CRC_NONE;
        remaining_next        = remaining_reg;
        span_next             = span_reg;
        case (phase_reg)
            PH_IDLE: begin
                push_entry.byte_index = 9'd0;
                push_entry.op         = CRC_START;
                push                  = in_valid && (in_byte == slave_address);
                if (push) span_next = 9'd0;
            end
            PH_CODE: begin
                push = in_valid;
                if (is_short_code) begin
                    push_entry.op = CRC_FEED;
                    if (in_valid) begin
                        remaining_next = SHORT_DATA_LEN;
                        span_next      = SHORT_DATA_LEN;
                    end
                end else if (in_byte == FC_WRITE_MULTI) begin
                    push_entry.op = CRC_FEED;
                    if (in_valid) begin
                        remaining_next = MULTI_HEAD_LEN;
                        span_next      = MULTI_SPAN_BASE;
                    end
                end else begin
                    push_entry.frame_end = 1'b1;
                    push_entry.aborted   = 1'b1;
                end
            end
            PH_HEAD: begin
                push          = in_valid;
                push_entry.op = CRC_FEED;
                if (in_valid) begin
                    if (last_in_phase) begin
                        remaining_next = {1'b0, in_byte} + MULTI_TAIL_LEN;
                        span_next      = {1'b0, in_byte} + MULTI_SPAN_BASE;
                    end else begin
                        remaining_next = remaining_reg - 9'd1;
                    end
                end
            end
            PH_DATA: begin
                push = in_valid;
                if (count_reg < span_reg) push_entry.op = CRC_FEED;
                else if (count_reg == span_reg) push_entry.op = CRC_CHK_LO;
                else push_entry.op = CRC_CHK_HI;
                push_entry.frame_end = last_in_phase;
                push_entry.len_ok    = ({1'b0, span_reg} + 10'd2) <= MaxLen;
                if (in_valid) remaining_next = last_in_phase ? 9'd0 : remaining_reg - 9'd1;
            end
            default: begin
                push = 1'b0;
            end
        endcase
        count_next = push ? push_entry.byte_index + 9'd1 : count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            remaining_reg <= '0;
            span_reg      <= '0;
            count_reg     <= '0;
        end else begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            span_reg      <= span_next;
            count_reg     <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/mrtu_queue.sv
// Short FIFO of tagged frame words between the front end and the CRC back end.
// Depends on mrtu_pkg.
`default_nettype none
module mrtu_queue
    import mrtu_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire mrtu_entry_t  push_entry,
    output logic              not_full,
    input  wire logic         pop,
    output logic              not_empty,
    output mrtu_entry_t       pop_entry
);

    mrtu_entry_t mem [QUEUE_DEPTH];

    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   level_reg, level_next;

    assign not_full  = (level_reg != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (level_reg != '0);
    assign pop_entry = mem[rd_ptr_reg];

    always_comb begin
        level_next = level_reg;
        if (push && !pop) level_next = level_reg + 1'b1;
        else if (pop && !push) level_next = level_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            level_reg <= level_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/mrtu_back.sv
// Back end: runs the CRC-16 over queued words, checks the trailer and holds the output word.
// Depends on mrtu_pkg.
`default_nettype none
module mrtu_back
    import mrtu_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_valid,
    input  wire mrtu_entry_t  q_entry,
    output logic              q_pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [7:0]        out_byte,
    output logic [8:0]        out_index,
    output logic              out_end,
    output logic              out_crc_ok,
    output logic              out_aborted
);

    logic [15:0] crc_reg, crc_next;
    logic        hi_match_reg, hi_match_next;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic [8:0]  index_reg;
    logic        end_reg, ok_reg, abort_reg;
    logic        ok_next;

    assign q_pop = q_valid && (!valid_reg || out_ready);

    always_comb begin
        crc_next      = crc_reg;
        hi_match_next = hi_match_reg;
        case (q_entry.op)
            CRC_START: begin
                crc_next      = crc16_feed(CRC_INIT, q_entry.frame_byte);
                hi_match_next = 1'b0;
            end
            CRC_FEED:   crc_next = crc16_feed(crc_reg, q_entry.frame_byte);
            CRC_CHK_LO: hi_match_next = (q_entry.frame_byte == crc_reg[7:0]);
            default: begin
                crc_next = crc_reg;
            end
        endcase
        ok_next = q_entry.frame_end && q_entry.len_ok && (q_entry.op == CRC_CHK_HI) &&
                  hi_match_reg && (q_entry.frame_byte == crc_reg[15:8]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= CRC_INIT;
            hi_match_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end else begin
            if (q_pop) begin
                crc_reg      <= crc_next;
                hi_match_reg <= hi_match_next;
                valid_reg    <= 1'b1;
            end else if (out_ready) begin
                valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            byte_reg  <= q_entry.frame_byte;
            index_reg <= q_entry.byte_index;
            end_reg   <= q_entry.frame_end;
            ok_reg    <= ok_next;
            abort_reg <= q_entry.aborted;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign out_index   = index_reg;
    assign out_end     = end_reg;
    assign out_crc_ok  = ok_reg;
    assign out_aborted = abort_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/modbus_rtu_frame_receiver_unit.sv
// Modbus RTU frame receiver top level: front end, word queue and CRC back end.
// Depends on mrtu_pkg, mrtu_front, mrtu_queue and mrtu_back.
//
// Accepts one received byte per cycle while the queue has room and returns each
// frame byte with its index; the last byte of a frame carries tlast and the
// CRC-16 verdict. Bytes outside a frame are dropped. The front end classifies a
// byte in the cycle it is taken, the four-word queue absorbs output stalls, and
// the back end folds the byte into the CRC through a 256-entry table lookup;
// a word is written into the queue and then into the back-end output register.
`default_nettype none
module modbus_rtu_frame_receiver_unit
    import mrtu_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,      // slave_address
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,        // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,        // [7:0] frame_byte, [16:8] byte_index, rest 0
    output logic             m_tlast,
    output logic [1:0]       m_tuser         // [0] crc_ok, [1] aborted
);

    logic [7:0]  slave_address_reg;
    logic        fifo_not_full, fifo_not_empty;
    logic        push, pop;
    mrtu_entry_t push_entry, pop_entry;
    logic [7:0]  out_byte;
    logic [8:0]  out_index;
    logic        out_crc_ok, out_aborted;

    always_ff @(posedge aclk) begin
        if (!aresetn) slave_address_reg <= 8'h01;
        else if (cfg_we) slave_address_reg <= cfg_wdata;
    end

    assign s_tready = fifo_not_full;

    mrtu_front #(.MAX_FRAME(MAX_FRAME)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .slave_address (slave_address_reg),
        .in_valid      (s_tvalid && fifo_not_full),
        .in_byte       (s_tdata),
        .push          (push),
        .push_entry    (push_entry)
    );

    mrtu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .not_full   (fifo_not_full),
        .pop        (pop),
        .not_empty  (fifo_not_empty),
        .pop_entry  (pop_entry)
    );

    mrtu_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (fifo_not_empty),
        .q_entry     (pop_entry),
        .q_pop       (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (out_byte),
        .out_index   (out_index),
        .out_end     (m_tlast),
        .out_crc_ok  (out_crc_ok),
        .out_aborted (out_aborted)
    );

    assign m_tdata = {7'd0, out_index, out_byte};
    assign m_tuser = {out_aborted, out_crc_ok};

endmodule
`default_nettype wire

FILE: hw/rtl/mrtu_checker.sv
// Port-level checks for the Modbus RTU frame receiver, bound to the top level.
// Depends on modbus_rtu_frame_receiver_unit.
`default_nettype none
module mrtu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [1:0]  m_tuser
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_abort_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
        else $error("aborted word without frame end or with crc_ok");

    a_ok_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("crc_ok outside frame end");

    a_abort_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[16:8] == 9'd1)
        else $error("abort not on function code byte");

endmodule

bind modbus_rtu_frame_receiver_unit mrtu_checker u_mrtu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire

FILE: sim/tb.sv
// Testbench for modbus_rtu_frame_receiver_unit: drives received bytes, checks frame words.
// Depends on mrtu_pkg and the RTL; a scoreboard class predicts each word the block returns.
`default_nettype none
module tb;
    import mrtu_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int ERROR_PRINTS = 40;
    localparam int LONG_STALL   = 300;

    typedef enum int {
        FAULT_NONE,
        FAULT_LO,
        FAULT_HI
    } crc_fault_t;

    class rtu_frame_tracker;
        typedef struct {
            logic [7:0] frame_byte;
            logic [8:0] byte_index;
            bit         frame_end;
            bit         crc_ok;
            bit         aborted;
        } frame_word_t;

        logic [7:0]  station;
        rx_phase_t   phase;
        logic [8:0]  left;
        logic [8:0]  span;
        logic [8:0]  frame_count;
        logic [15:0] crc_reg;
        bit          lo_matched;
        frame_word_t expected_words[$];
        int          mismatches;
        int          words_predicted;

        function new();
            station         = 8'h01;
            phase           = PH_IDLE;
            left            = '0;
            span            = '0;
            frame_count     = '0;
            crc_reg         = CRC_INIT;
            lo_matched      = 1'b0;
            mismatches      = 0;
            words_predicted = 0;
        endfunction

        static function logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {8'h00, b};
            for (int k = 0; k < 8; k++) begin
                if (c[0]) c = (c >> 1) ^ CRC_POLY;
                else c = c >> 1;
            end
            return c;
        endfunction

        function void set_station(input logic [7:0] a);
            station = a;
        endfunction

        function void note_rx_byte(input logic [7:0] b);
            frame_word_t w;
            logic [8:0]  idx;
            bit          fin;
            bit          good;
            bit          abort_flag;
            idx        = frame_count;
            fin        = 1'b0;
            good       = 1'b0;
            abort_flag = 1'b0;
            case (phase)
                PH_IDLE: begin
                    if (b != station) return;
                    idx        = '0;
                    crc_reg    = crc16_step(CRC_INIT, b);
                    lo_matched = 1'b0;
                    span       = '0;
                    phase      = PH_CODE;
                end
                PH_CODE: begin
                    if (b == FC_READ_HOLDING || b == FC_READ_INPUT || b == FC_WRITE_SINGLE) begin
                        crc_reg = crc16_step(crc_reg, b);
                        left    = SHORT_DATA_LEN;
                        span    = SHORT_DATA_LEN;
                        phase   = PH_DATA;
                    end else if (b == FC_WRITE_MULTI) begin
                        crc_reg = crc16_step(crc_reg, b);
                        left    = MULTI_HEAD_LEN;
                        span    = MULTI_SPAN_BASE;
                        phase   = PH_HEAD;
                    end else begin
                        fin        = 1'b1;
                        abort_flag = 1'b1;
                        phase      = PH_IDLE;
                    end
                end
                PH_HEAD: begin
                    crc_reg = crc16_step(crc_reg, b);
                    if (left <= 9'd1) begin
                        left  = {1'b0, b} + MULTI_TAIL_LEN;
                        span  = {1'b0, b} + MULTI_SPAN_BASE;
                        phase = PH_DATA;
                    end else begin
                        left = left - 9'd1;
                    end
                end
                default: begin
                    if (idx < span) crc_reg = crc16_step(crc_reg, b);
                    else if (idx == span) lo_matched = (b == crc_reg[7:0]);
                    else good = lo_matched && (b == crc_reg[15:8]);
                    if (left <= 9'd1) begin
                        fin = 1'b1;
                        if (int'(span) + 2 > MAX_FRAME_DEFAULT) good = 1'b0;
                        left  = '0;
                        phase = PH_IDLE;
                    end else begin
                        left = left - 9'd1;
                        good = 1'b0;
                    end
                end
            endcase
            if (!fin) good = 1'b0;
            w.frame_byte = b;
            w.byte_index = idx;
            w.frame_end  = fin;
            w.crc_ok     = good;
            w.aborted    = abort_flag;
            expected_words.push_back(w);
            words_predicted++;
            frame_count = idx + 9'd1;
        endfunction

        function void report_field(input string name, input int exp_v, input int act_v);
            if (exp_v != act_v) begin
                mismatches++;
                if (mismatches <= ERROR_PRINTS)
                    $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            end
        endfunction

        function void check_frame_word(input logic [7:0] fb, input logic [8:0] bi,
                                       input logic fe, input logic ok, input logic ab);
            frame_word_t w;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= ERROR_PRINTS)
                    $error("frame_byte unexpected word: expected none, actual %0d", fb);
                return;
            end
            w = expected_words.pop_front();
            report_field("frame_byte", w.frame_byte, fb);
            report_field("byte_index", w.byte_index, bi);
            report_field("frame_end", w.frame_end, fe);
            report_field("crc_ok", w.crc_ok, ok);
            report_field("aborted", w.aborted, ab);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    rtu_frame_tracker sb;
    logic [7:0] station_addr    = 8'h01;
    int         src_idle_pct    = 0;
    int         dst_idle_pct    = 0;
    bit         long_stall_req  = 1'b0;
    bit         long_stall_seen = 1'b0;
    int         long_stall_cnt  = 0;
    int         cycles          = 0;

    modbus_rtu_frame_receiver_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // hold off the output once for a long stretch, otherwise stall at random
    always @(posedge aclk) begin
        if (long_stall_cnt != 0) begin
            m_tready       <= 1'b0;
            long_stall_cnt <= long_stall_cnt - 1;
        end else if (long_stall_req && !long_stall_seen) begin
            m_tready        <= 1'b0;
            long_stall_cnt  <= LONG_STALL;
            long_stall_seen <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_frame_word(m_tdata[7:0], m_tdata[16:8], m_tlast, m_tuser[0], m_tuser[1]);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_rx_byte(b);
    endtask

    task automatic send_request(input logic [7:0] code, input int n_data,
                                input crc_fault_t fault);
        logic [7:0]  req[$];
        logic [15:0] crc;
        int          body;
        req.push_back(station_addr);
        req.push_back(code);
        if (code == FC_WRITE_MULTI) body = 4 + 1 + n_data;
        else body = 4;
        for (int i = 0; i < body; i++) begin
            if (code == FC_WRITE_MULTI && i == 4) req.push_back(8'(n_data));
            else if ($urandom_range(7) == 0) req.push_back(station_addr);
            else req.push_back(8'($urandom_range(255)));
        end
        crc = CRC_INIT;
        foreach (req[i]) crc = rtu_frame_tracker::crc16_step(crc, req[i]);
        if (fault == FAULT_LO) crc[7:0] = crc[7:0] ^ 8'($urandom_range(1, 255));
        if (fault == FAULT_HI) crc[15:8] = crc[15:8] ^ 8'($urandom_range(1, 255));
        req.push_back(crc[7:0]);
        req.push_back(crc[15:8]);
        foreach (req[i]) send_byte(req[i]);
    endtask

    task automatic send_abort(input logic [7:0] code);
        send_byte(station_addr);
        send_byte(code);
    endtask

    task automatic write_station(input logic [7:0] a);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_station(a);
        station_addr = a;
    endtask

    task automatic random_traffic(input int word_target);
        int          r;
        int          n;
        logic [7:0]  code;
        crc_fault_t  fault;
        while (sb.words_predicted < word_target) begin
            r = $urandom_range(99);
            if (r < 6) begin
                send_byte(8'($urandom_range(255)));
            end else if (r < 12) begin
                do code = 8'($urandom_range(255));
                while (code == FC_READ_HOLDING || code == FC_READ_INPUT ||
                       code == FC_WRITE_SINGLE || code == FC_WRITE_MULTI);
                send_abort(code);
            end else if (r < 18) begin
                // broken request: header only, the next bytes run into it
                send_byte(station_addr);
                case ($urandom_range(3))
                    0: send_byte(FC_READ_HOLDING);
                    1: send_byte(FC_READ_INPUT);
                    2: send_byte(FC_WRITE_SINGLE);
                    default: send_byte(FC_WRITE_MULTI);
                endcase
                n = $urandom_range(4);
                repeat (n) send_byte(8'($urandom_range(255)));
            end else begin
                case ($urandom_range(3))
                    0: code = FC_READ_HOLDING;
                    1: code = FC_READ_INPUT;
                    2: code = FC_WRITE_SINGLE;
                    default: code = FC_WRITE_MULTI;
                endcase
                if ($urandom_range(199) < 3) n = $urandom_range(240, 255);
                else n = $urandom_range(12);
                r = $urandom_range(99);
                if (r < 75) fault = FAULT_NONE;
                else if (r < 88) fault = FAULT_LO;
                else fault = FAULT_HI;
                send_request(code, n, fault);
            end
        end
    endtask

    initial begin
        sb = new();
        src_idle_pct = 27;
        dst_idle_pct = 46;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_request(FC_READ_HOLDING, 0, FAULT_NONE);
        send_request(FC_READ_INPUT, 0, FAULT_LO);
        send_abort(8'h00);
        send_abort(8'hFF);
        send_request(FC_WRITE_SINGLE, 0, FAULT_HI);
        send_request(FC_WRITE_MULTI, 0, FAULT_NONE);

        write_station(8'h00);
        random_traffic(600);

        write_station(8'hFF);
        src_idle_pct = 46;
        dst_idle_pct = 27;
        random_traffic(1150);

        write_station(8'($urandom_range(255)));
        src_idle_pct   = 0;
        dst_idle_pct   = 0;
        long_stall_req = 1'b1;
        random_traffic(1700);

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/mrtu_pkg.sv
hw/rtl/mrtu_front.sv
hw/rtl/mrtu_queue.sv
hw/rtl/mrtu_back.sv
hw/rtl/modbus_rtu_frame_receiver_unit.sv
hw/rtl/mrtu_checker.sv
sim/tb.sv
